// ----- rtl/core/flua_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package flua_pkg;

	localparam int unsigned POOL_DEPTH_DEF = 4096;

	localparam int unsigned CFG_W  = 13;
	localparam int unsigned HIN_W  = 16;
	localparam int unsigned HOUT_W = 12;
	localparam int unsigned CNT_W  = 13;

	localparam logic [CFG_W-1:0] POOL_SIZE_RST = 13'd4096;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 13'h1FFF;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/flua_link_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module flua_link_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/free_list_unit_allocator.sv -----
// Channel   Direction  Handshake             Beat contents
// in        input      in_valid / in_ready   func, handle_in
// out       output     out_valid / out_ready handle_out, status, used_count
// cfg       input      cfg_we                cfg_wdata (pool_size)
//
// An allocate then passes through S_LINK with in_ready low: the link memory read at
// the head returns the new head in the cycle after the beat. Free and every rejected beat go straight back to S_RUN.
// After reset all POOL_DEPTH entries of the link memory are swept (entry i <- i+1)
// with in_ready low; cfg writes are taken during the sweep.
// A result held in the output register stalls input only while out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module free_list_unit_allocator
	import flua_pkg::*;
#(
	parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              func,
	input  wire logic [HIN_W-1:0]  handle_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [HOUT_W-1:0] handle_out,
	output logic      [1:0]        status,
	output logic      [CNT_W-1:0]  used_count,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	localparam int unsigned ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int unsigned LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int unsigned CMP_W  = (LINK_W > HIN_W) ? LINK_W : HIN_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_DEPTH - 1);
	localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(POOL_DEPTH);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_RUN,
		S_LINK
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [LINK_W-1:0]   head_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CFG_W-1:0]    pool_size_q;
	logic                out_valid_q;
	logic [HOUT_W-1:0]   handle_out_q;
	status_t             status_q;
	logic [CNT_W-1:0]    used_count_q;

	logic [CMP_W-1:0]    lim;
	logic [CMP_W-1:0]    size_ext;
	logic                accept;
	logic                is_free;
	logic                alloc_ok;
	logic                free_ok;
	logic [CNT_W-1:0]    cnt_nxt;
	status_t             status_nxt;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [LINK_W-1:0]   ram_wdata;
	logic [LINK_W-1:0]   ram_rdata;

	assign size_ext = CMP_W'(pool_size_q);
	assign lim      = (size_ext > DEPTH_CMP) ? DEPTH_CMP : size_ext;
	assign in_ready = (state_q == S_RUN) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_free  = (func == FUNC_FREE);
	assign alloc_ok = accept && !is_free && (CMP_W'(head_q) < lim);
	assign free_ok  = accept && is_free && (CMP_W'(handle_in) < lim);

	always_comb begin
		cnt_nxt = cnt_q;
		if (alloc_ok && (cnt_q != COUNT_MAX)) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (free_ok && (cnt_q != '0)) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		status_nxt = ST_OK;
		if (accept && !is_free && !alloc_ok) begin
			status_nxt = ST_EMPTY;
		end else if (accept && is_free && !free_ok) begin
			status_nxt = ST_RANGE;
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = LINK_W'(clr_q) + LINK_W'(1);
		end else begin
			ram_we    = free_ok;
			ram_waddr = handle_in[ADDR_W-1:0];
			ram_wdata = head_q;
		end
	end

	flua_link_ram #(
		.DEPTH (POOL_DEPTH),
		.AW    (ADDR_W),
		.DW    (LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (alloc_ok),
		.raddr (head_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			head_q       <= '0;
			cnt_q        <= '0;
			pool_size_q  <= POOL_SIZE_RST;
			out_valid_q  <= 1'b0;
			handle_out_q <= '0;
			status_q     <= ST_OK;
			used_count_q <= '0;
		end else begin
			if (cfg_we) begin
				pool_size_q <= cfg_wdata;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (accept) begin
						handle_out_q <= alloc_ok ? HOUT_W'(head_q) : '0;
						status_q     <= status_nxt;
						used_count_q <= cnt_nxt;
						cnt_q        <= cnt_nxt;
						if (alloc_ok) begin
							state_q <= S_LINK;
						end
						if (free_ok) begin
							head_q <= LINK_W'(handle_in);
						end
					end
				end
				S_LINK: begin
					head_q  <= ram_rdata;
					state_q <= S_RUN;
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign handle_out = handle_out_q;
	assign status     = status_q;
	assign used_count = used_count_q;

endmodule

`default_nettype wire

// ----- rtl/core/flua_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module flua_checker
	import flua_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              func,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [HOUT_W-1:0] handle_out,
	input wire logic [1:0]        status,
	input wire logic [CNT_W-1:0]  used_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(handle_out)
			&& $stable(status) && $stable(used_count))
		else $error("result changed while stalled");

	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat gave no result");

	a_alloc_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_ALLOC) ##1 (status == ST_OK) |-> !in_ready)
		else $error("beat taken before head reload");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> handle_out == '0)
		else $error("handle granted with error status");

endmodule

bind free_list_unit_allocator flua_checker u_flua_checker (.*);

`default_nettype wire

// ----- verif/tb_free_list_unit_allocator.sv -----
`timescale 1ns / 1ps

module tb_free_list_unit_allocator;
	import flua_pkg::*;

	localparam int unsigned HOLD_LEN    = 120;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [HOUT_W-1:0] handle;
		status_t           st;
		logic [CNT_W-1:0]  used;
	} grant_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	func_t             func      = FUNC_ALLOC;
	logic [HIN_W-1:0]  handle_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [HOUT_W-1:0] handle_out;
	logic [1:0]        status;
	logic [CNT_W-1:0]  used_count;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	// free list mirror
	logic [CNT_W-1:0]  fl_link [POOL_DEPTH_DEF];
	logic [CNT_W-1:0]  fl_head;
	logic [CNT_W-1:0]  fl_used;
	logic [CFG_W-1:0]  pool_cfg;

	grant_t            pending_grants [$];
	logic [HOUT_W-1:0] held [$];

	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;
	logic        hold_start = 1'b0;
	int unsigned hold_left  = 0;
	int unsigned err_cnt    = 0;
	int unsigned beats_in   = 0;
	int unsigned beats_out  = 0;
	int unsigned cycle_cnt  = 0;

	free_list_unit_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.handle_out (handle_out),
		.status     (status),
		.used_count (used_count),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				pending_grants.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned pool_limit();
		return (pool_cfg > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : int'(pool_cfg);
	endfunction

	function automatic grant_t alloc_free_predict(input func_t f, input logic [HIN_W-1:0] h);
		grant_t      r;
		int unsigned lim;
		lim      = pool_limit();
		r.handle = '0;
		r.st     = ST_OK;
		if (f == FUNC_ALLOC) begin
			if (fl_head >= lim) begin
				r.st = ST_EMPTY;
			end else begin
				r.handle = fl_head[HOUT_W-1:0];
				fl_head  = fl_link[fl_head[HOUT_W-1:0]];
				if (fl_used != COUNT_MAX) fl_used = fl_used + 1'b1;
			end
		end else if (h >= lim) begin
			r.st = ST_RANGE;
		end else begin
			fl_link[h[HOUT_W-1:0]] = fl_head;
			fl_head                = h[CNT_W-1:0];
			if (fl_used != 0) fl_used = fl_used - 1'b1;
		end
		r.used = fl_used;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		err_cnt++;
		if (err_cnt <= 50)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		grant_t e;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result beat", handle_out, 0);
			end else begin
				e = pending_grants.pop_front();
				if (handle_out !== e.handle) report_mismatch("handle_out", handle_out, e.handle);
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (used_count !== e.used) report_mismatch("used_count", used_count, e.used);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left  = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_op(input func_t f, input logic [HIN_W-1:0] h);
		grant_t g;
		int     k;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		handle_in <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_in++;
		g = alloc_free_predict(f, h);
		pending_grants.push_back(g);
		if (g.st == ST_OK) begin
			if (f == FUNC_ALLOC) begin
				held.push_back(g.handle);
			end else begin
				k = 0;
				while (k < held.size() && held[k] != h) k++;
				if (k < held.size()) held.delete(k);
			end
		end
	endtask

	task automatic free_held();
		logic [HIN_W-1:0] h;
		if (held.size() == 0) h = HIN_W'($urandom);
		else h = held[$urandom_range(held.size() - 1)];
		send_op(FUNC_FREE, h);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pool(input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pool_cfg  = v;
	endtask

	task automatic test_basic_ops();
		write_pool(POOL_SIZE_RST);
		send_op(FUNC_ALLOC, 16'hFFFF);
		send_op(FUNC_ALLOC, 16'h0000);
		send_op(FUNC_FREE, 16'd0);
		send_op(FUNC_FREE, 16'hFFFF);
		send_op(FUNC_FREE, 16'd4096);
		send_op(FUNC_ALLOC, 16'h5A5A);
	endtask

	task automatic test_pool_resize();
		// shrink the pool to three entries: allocs run dry at the new limit
		write_pool(13'd3);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_FREE, 16'd2);
		send_op(FUNC_FREE, 16'd3);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_ALLOC, '0);
		write_pool(13'd0);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_FREE, 16'd0);
		// above the pool depth clamps
		write_pool(13'h1FFF);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_FREE, 16'd4096);
		write_pool(13'd1);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_FREE, 16'd0);
		send_op(FUNC_ALLOC, '0);
		send_op(FUNC_ALLOC, '0);
	endtask

	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
		input logic [CFG_W-1:0] size, input int unsigned n);
		int unsigned      pick;
		logic [HIN_W-1:0] h;
		write_pool(size);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_op(FUNC_ALLOC, HIN_W'($urandom));
			end else if (pick < 90) begin
				free_held();
			end else if (pick < 95) begin
				send_op(FUNC_FREE, HIN_W'($urandom));
			end else begin
				h = HIN_W'(pool_limit() + $urandom_range(3));
				send_op(FUNC_FREE, h);
			end
		end
	endtask

	task automatic test_backpressure();
		write_pool(13'd16);
		idle_pct  = 0;
		stall_pct = 0;
		repeat (2) begin
			hold_start = 1'b1;
			repeat (12) send_op(FUNC_ALLOC, HIN_W'($urandom));
			repeat (12) free_held();
			wait_idle();
		end
	endtask

	task automatic test_count_limits();
		write_pool(POOL_SIZE_RST);
		idle_pct  = 0;
		stall_pct = 0;
		// repeated free of one handle loops it onto itself and pins the count at zero
		repeat (int'(fl_used) + 3) send_op(FUNC_FREE, 16'd5);
		repeat (24) send_op(FUNC_ALLOC, HIN_W'($urandom));
		repeat (3) send_op(FUNC_FREE, 16'd5);
		held.delete();
	endtask

	initial begin
		int unsigned k;
		for (k = 0; k < POOL_DEPTH_DEF; k++) fl_link[k] = CNT_W'(k + 1);
		fl_head  = '0;
		fl_used  = '0;
		pool_cfg = POOL_SIZE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_pool_resize();
		test_random_traffic(0, 0, 13'd16, 100);
		test_random_traffic(79, 0, 13'd1, 150);
		test_random_traffic(0, 79, 13'($urandom_range(2, 40)), 150);
		test_random_traffic(32, 32, POOL_SIZE_RST, 150);
		test_backpressure();
		test_count_limits();

		wait_idle();
		repeat (16) @(posedge clk);
		$display("Ran %0d input beats / %0d result beats: alloc and free at four idle mixes,",
			beats_in, beats_out);
		$display("pool sizes 0 to 8191 with resizes, output hold-off, double free, count floor.");
		if (err_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/flua_pkg.sv
rtl/core/flua_link_ram.sv
rtl/core/free_list_unit_allocator.sv
rtl/core/flua_checker.sv
verif/tb_free_list_unit_allocator.sv
